/* rtl/tbl_pkg.sv */
// Shared types, register codes and constants of the tilt bubble level tracker.
package tbl_pkg;

   localparam int MATRIX_COLS_DEF = 8;
   localparam int MATRIX_ROWS_DEF = 8;

   localparam int TRAVEL_Q8 = 819;
   localparam int SLEW_Q8   = 256;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 8;
   localparam int IDX_W      = 3;

   localparam int MUL_W  = 25;
   localparam int PROD_W = 2 * MUL_W;
   localparam int TILT_W = 24;
   localparam int POS_W  = 16;
   localparam int ACC_W  = 48;

   localparam int AXIS_SWAP  = 0;
   localparam int AXIS_NEG_X = 1;
   localparam int AXIS_NEG_Y = 2;

   typedef enum logic [2:0] {
      REG_X_OFFSET    = 3'd0,
      REG_Y_OFFSET    = 3'd1,
      REG_AXIS_MODE   = 3'd2,
      REG_TILT_ALPHA  = 3'd3,
      REG_LEVEL_ENTER = 3'd4,
      REG_LEVEL_EXIT  = 3'd5,
      REG_PIXEL_GAIN  = 3'd6,
      REG_POS_WEIGHT  = 3'd7
   } reg_type;

   typedef struct packed {
      logic signed [15:0] x_offset;
      logic signed [15:0] y_offset;
      logic [2:0]         axis_mode;
      logic [15:0]        tilt_alpha;
      logic [14:0]        level_enter;
      logic [14:0]        level_exit;
      logic [15:0]        pixel_gain;
      logic [15:0]        pos_weight;
   } cfg_type;

   typedef enum logic [3:0] {
      OP_TILT_X = 4'd0,
      OP_TILT_Y = 4'd1,
      OP_SQ_X   = 4'd2,
      OP_SQ_Y   = 4'd3,
      OP_ENTER  = 4'd4,
      OP_EXIT   = 4'd5,
      OP_PIX_X  = 4'd6,
      OP_PIX_Y  = 4'd7,
      OP_POS_X  = 4'd8,
      OP_POS_Y  = 4'd9
   } op_type;

   localparam op_type OP_FIRST = OP_TILT_X;
   localparam op_type OP_LAST  = OP_POS_Y;

   typedef struct packed {
      logic   load;
      logic   mul_en;
      logic   wb_en;
      op_type op;
      logic   slew;
      logic   out_load;
   } cmd_type;

endpackage

/* rtl/tbl_csr.sv */
// Configuration register file behind the APB-style port.
module tbl_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [tbl_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [tbl_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [tbl_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready,
   output tbl_pkg::cfg_type                  cfg
);

   tbl_pkg::cfg_type cfg_ff;
   tbl_pkg::cfg_type cfg_in;
   tbl_pkg::reg_type reg_idx;
   logic             write_en;

   assign reg_idx    = tbl_pkg::reg_type'(csr_paddr[tbl_pkg::CSR_ADDR_W-1:2]);
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (reg_idx)
            tbl_pkg::REG_X_OFFSET:    cfg_in.x_offset    = csr_pwdata[15:0];
            tbl_pkg::REG_Y_OFFSET:    cfg_in.y_offset    = csr_pwdata[15:0];
            tbl_pkg::REG_AXIS_MODE:   cfg_in.axis_mode   = csr_pwdata[2:0];
            tbl_pkg::REG_TILT_ALPHA:  cfg_in.tilt_alpha  = csr_pwdata[15:0];
            tbl_pkg::REG_LEVEL_ENTER: cfg_in.level_enter = csr_pwdata[14:0];
            tbl_pkg::REG_LEVEL_EXIT:  cfg_in.level_exit  = csr_pwdata[14:0];
            tbl_pkg::REG_PIXEL_GAIN:  cfg_in.pixel_gain  = csr_pwdata[15:0];
            tbl_pkg::REG_POS_WEIGHT:  cfg_in.pos_weight  = csr_pwdata[15:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         tbl_pkg::REG_X_OFFSET:    csr_prdata = {16'd0, cfg_ff.x_offset};
         tbl_pkg::REG_Y_OFFSET:    csr_prdata = {16'd0, cfg_ff.y_offset};
         tbl_pkg::REG_AXIS_MODE:   csr_prdata = {29'd0, cfg_ff.axis_mode};
         tbl_pkg::REG_TILT_ALPHA:  csr_prdata = {16'd0, cfg_ff.tilt_alpha};
         tbl_pkg::REG_LEVEL_ENTER: csr_prdata = {17'd0, cfg_ff.level_enter};
         tbl_pkg::REG_LEVEL_EXIT:  csr_prdata = {17'd0, cfg_ff.level_exit};
         tbl_pkg::REG_PIXEL_GAIN:  csr_prdata = {16'd0, cfg_ff.pixel_gain};
         tbl_pkg::REG_POS_WEIGHT:  csr_prdata = {16'd0, cfg_ff.pos_weight};
         default:                  csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x_offset    <= 16'sd0;
         cfg_ff.y_offset    <= 16'sd0;
         cfg_ff.axis_mode   <= 3'd4;
         cfg_ff.tilt_alpha  <= 16'd11796;
         cfg_ff.level_enter <= 15'd410;
         cfg_ff.level_exit  <= 15'd573;
         cfg_ff.pixel_gain  <= 16'd1365;
         cfg_ff.pos_weight  <= 16'd22938;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* rtl/tbl_datapath.sv */
// Datapath with one shared multiplier, filter state, level latch and result register.
module tbl_datapath #(
   parameter int MATRIX_COLS = tbl_pkg::MATRIX_COLS_DEF,
   parameter int MATRIX_ROWS = tbl_pkg::MATRIX_ROWS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  tbl_pkg::cmd_type                  cmd,
   input  tbl_pkg::cfg_type                  cfg,
   input  logic [tbl_pkg::REQ_DATA_W-1:0]    req_data,
   output logic [tbl_pkg::RSP_DATA_W-1:0]    rsp_data
);

   localparam int MUL_W  = tbl_pkg::MUL_W;
   localparam int PROD_W = tbl_pkg::PROD_W;
   localparam int TILT_W = tbl_pkg::TILT_W;
   localparam int POS_W  = tbl_pkg::POS_W;
   localparam int ACC_W  = tbl_pkg::ACC_W;
   localparam int IDX_W  = tbl_pkg::IDX_W;

   localparam logic signed [POS_W-1:0]  CX = POS_W'((MATRIX_COLS - 1) * 128);
   localparam logic signed [POS_W-1:0]  CY = POS_W'((MATRIX_ROWS - 1) * 128);
   localparam logic signed [PROD_W-1:0] PIX_MAX = PROD_W'(tbl_pkg::TRAVEL_Q8);
   localparam logic signed [PROD_W-1:0] PIX_MIN = -PROD_W'(tbl_pkg::TRAVEL_Q8);
   localparam logic signed [POS_W:0]    SLEW_MAX = (POS_W + 1)'(tbl_pkg::SLEW_Q8);
   localparam logic signed [POS_W:0]    SLEW_MIN = -((POS_W + 1)'(tbl_pkg::SLEW_Q8));
   localparam logic [7:0]               COL_MAX = 8'(MATRIX_COLS - 1);
   localparam logic [7:0]               ROW_MAX = 8'(MATRIX_ROWS - 1);

   logic signed [15:0]        rx_ff, rx_in, ry_ff, ry_in;
   logic signed [TILT_W-1:0]  tx_ff, tx_in, ty_ff, ty_in;
   logic signed [POS_W-1:0]   px_ff, px_in, py_ff, py_in;
   logic signed [POS_W-1:0]   sx_ff, sx_in, sy_ff, sy_in;
   logic signed [POS_W-1:0]   tgt_x_ff, tgt_x_in, tgt_y_ff, tgt_y_in;
   logic [ACC_W-1:0]          acc_ff, acc_in;
   logic                      level_ff, level_in;
   logic signed [PROD_W-1:0]  prod_ff;
   logic [tbl_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic signed [15:0]        dx, dy;
   logic signed [15:0]        ax, ay, bx, by;
   logic signed [MUL_W-1:0]   mul_a, mul_b;
   logic signed [PROD_W-1:0]  lp_shift, pix_shift;
   logic signed [POS_W-1:0]   pix_off;
   logic [ACC_W-1:0]          thr;
   logic signed [POS_W:0]     dsx, dsy;
   logic [IDX_W-1:0]          row_idx, col_idx;

   function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
      if (v > 17'sd32767) begin
         return 16'sh7fff;
      end else if (v < -17'sd32768) begin
         return 16'sh8000;
      end else begin
         return v[15:0];
      end
   endfunction

   function automatic logic signed [POS_W-1:0] slew_step(
      input logic signed [POS_W-1:0] prev,
      input logic signed [POS_W-1:0] now,
      input logic signed [POS_W:0]   d
   );
      if (d > SLEW_MAX) begin
         return prev + POS_W'(tbl_pkg::SLEW_Q8);
      end else if (d < SLEW_MIN) begin
         return prev - POS_W'(tbl_pkg::SLEW_Q8);
      end else begin
         return now;
      end
   endfunction

   function automatic logic [IDX_W-1:0] to_index(
      input logic signed [POS_W-1:0] q8,
      input logic [7:0]              max_idx
   );
      logic [POS_W-1:0] sum;
      logic [7:0]       r;
      sum = {1'b0, q8[POS_W-2:0]} + POS_W'(128);
      r   = q8[POS_W-1] ? 8'd0 : sum[POS_W-1:8];
      if (r > max_idx) begin
         r = max_idx;
      end
      return r[IDX_W-1:0];
   endfunction

   // Sample capture: offset removal, then axis swap and flips.
   always_comb begin
      dx = sat16(17'($signed(req_data[15:0])) - 17'(cfg.x_offset));
      dy = sat16(17'($signed(req_data[31:16])) - 17'(cfg.y_offset));
      ax = dx;
      ay = dy;
      bx = cfg.axis_mode[tbl_pkg::AXIS_SWAP] ? ay : ax;
      by = cfg.axis_mode[tbl_pkg::AXIS_SWAP] ? ax : ay;
      rx_in = rx_ff;
      ry_in = ry_ff;
      if (cmd.load) begin
         rx_in = cfg.axis_mode[tbl_pkg::AXIS_NEG_X] ? sat16(-{bx[15], bx}) : bx;
         ry_in = cfg.axis_mode[tbl_pkg::AXIS_NEG_Y] ? sat16(-{by[15], by}) : by;
      end
   end

   always_comb begin
      case (cmd.op)
         tbl_pkg::OP_TILT_X: begin
            mul_a = MUL_W'($signed({rx_ff, 8'd0})) - MUL_W'(tx_ff);
            mul_b = MUL_W'({1'b0, cfg.tilt_alpha});
         end
         tbl_pkg::OP_TILT_Y: begin
            mul_a = MUL_W'($signed({ry_ff, 8'd0})) - MUL_W'(ty_ff);
            mul_b = MUL_W'({1'b0, cfg.tilt_alpha});
         end
         tbl_pkg::OP_SQ_X: begin
            mul_a = MUL_W'(tx_ff);
            mul_b = MUL_W'(tx_ff);
         end
         tbl_pkg::OP_SQ_Y: begin
            mul_a = MUL_W'(ty_ff);
            mul_b = MUL_W'(ty_ff);
         end
         tbl_pkg::OP_ENTER: begin
            mul_a = MUL_W'({1'b0, cfg.level_enter});
            mul_b = MUL_W'({1'b0, cfg.level_enter});
         end
         tbl_pkg::OP_EXIT: begin
            mul_a = MUL_W'({1'b0, cfg.level_exit});
            mul_b = MUL_W'({1'b0, cfg.level_exit});
         end
         tbl_pkg::OP_PIX_X: begin
            mul_a = MUL_W'(tx_ff);
            mul_b = MUL_W'({1'b0, cfg.pixel_gain});
         end
         tbl_pkg::OP_PIX_Y: begin
            mul_a = MUL_W'(ty_ff);
            mul_b = MUL_W'({1'b0, cfg.pixel_gain});
         end
         tbl_pkg::OP_POS_X: begin
            mul_a = MUL_W'(tgt_x_ff) - MUL_W'(px_ff);
            mul_b = MUL_W'({1'b0, cfg.pos_weight});
         end
         tbl_pkg::OP_POS_Y: begin
            mul_a = MUL_W'(tgt_y_ff) - MUL_W'(py_ff);
            mul_b = MUL_W'({1'b0, cfg.pos_weight});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      lp_shift  = (prod_ff + PROD_W'(32768)) >>> 16;
      pix_shift = (prod_ff + PROD_W'(524288)) >>> 20;
      if (pix_shift > PIX_MAX) begin
         pix_off = POS_W'(tbl_pkg::TRAVEL_Q8);
      end else if (pix_shift < PIX_MIN) begin
         pix_off = -POS_W'(tbl_pkg::TRAVEL_Q8);
      end else begin
         pix_off = pix_shift[POS_W-1:0];
      end
      thr = {2'b00, prod_ff[29:0], 16'd0};
   end

   always_comb begin
      tx_in    = tx_ff;
      ty_in    = ty_ff;
      px_in    = px_ff;
      py_in    = py_ff;
      tgt_x_in = tgt_x_ff;
      tgt_y_in = tgt_y_ff;
      acc_in   = acc_ff;
      level_in = level_ff;
      if (cmd.wb_en) begin
         case (cmd.op)
            tbl_pkg::OP_TILT_X: tx_in = tx_ff + lp_shift[TILT_W-1:0];
            tbl_pkg::OP_TILT_Y: ty_in = ty_ff + lp_shift[TILT_W-1:0];
            tbl_pkg::OP_SQ_X:   acc_in = prod_ff[ACC_W-1:0];
            tbl_pkg::OP_SQ_Y:   acc_in = acc_ff + prod_ff[ACC_W-1:0];
            tbl_pkg::OP_ENTER: begin
               if (!level_ff && (acc_ff <= thr)) begin
                  level_in = 1'b1;
               end
            end
            tbl_pkg::OP_EXIT: begin
               if (level_ff && (acc_ff >= thr)) begin
                  level_in = 1'b0;
               end
            end
            tbl_pkg::OP_PIX_X:  tgt_x_in = CX + pix_off;
            tbl_pkg::OP_PIX_Y:  tgt_y_in = CY - pix_off;
            tbl_pkg::OP_POS_X:  px_in = px_ff + lp_shift[POS_W-1:0];
            tbl_pkg::OP_POS_Y:  py_in = py_ff + lp_shift[POS_W-1:0];
            default:            acc_in = acc_ff;
         endcase
      end
   end

   always_comb begin
      dsx   = (POS_W + 1)'(px_ff) - (POS_W + 1)'(sx_ff);
      dsy   = (POS_W + 1)'(py_ff) - (POS_W + 1)'(sy_ff);
      sx_in = sx_ff;
      sy_in = sy_ff;
      if (cmd.slew) begin
         sx_in = slew_step(sx_ff, px_ff, dsx);
         sy_in = slew_step(sy_ff, py_ff, dsy);
      end
      col_idx     = to_index(sx_ff, COL_MAX);
      row_idx     = to_index(sy_ff, ROW_MAX);
      rsp_data_in = cmd.out_load ? {1'b0, col_idx, row_idx, level_ff} : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_ff    <= '0;
         ty_ff    <= '0;
         px_ff    <= CX;
         py_ff    <= CY;
         sx_ff    <= CX;
         sy_ff    <= CY;
         level_ff <= 1'b0;
      end else begin
         tx_ff    <= tx_in;
         ty_ff    <= ty_in;
         px_ff    <= px_in;
         py_ff    <= py_in;
         sx_ff    <= sx_in;
         sy_ff    <= sy_in;
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      rx_ff       <= rx_in;
      ry_ff       <= ry_in;
      tgt_x_ff    <= tgt_x_in;
      tgt_y_ff    <= tgt_y_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
      if (cmd.mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
   end

   assign rsp_data = rsp_data_ff;

endmodule

/* rtl/tbl_ctrl.sv */
// Controller that sequences the shared multiplier and owns both handshakes.
module tbl_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output tbl_pkg::cmd_type cmd
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_MUL    = 5'b00010,
      ST_WB     = 5'b00100,
      ST_SLEW   = 5'b01000,
      ST_RESULT = 5'b10000
   } state_type;

   state_type       state_ff, state_in;
   tbl_pkg::op_type op_ff, op_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            accept;
   logic            out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      cmd          = '0;
      cmd.op       = op_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               op_in    = tbl_pkg::OP_FIRST;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_WB;
         end
         ST_WB: begin
            cmd.wb_en = 1'b1;
            if (op_ff == tbl_pkg::OP_LAST) begin
               state_in = ST_SLEW;
            end else begin
               op_in    = tbl_pkg::op_type'(op_ff + 4'd1);
               state_in = ST_MUL;
            end
         end
         ST_SLEW: begin
            cmd.slew = 1'b1;
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = cmd.out_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= tbl_pkg::OP_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register loaded while a result is still waiting");

   a_accept_starts_seq: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_MUL && op_ff == tbl_pkg::OP_FIRST))
      else $error("request accepted without starting the sequence");

   a_wb_after_mul: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WB) |-> ($past(state_ff) == ST_MUL && $stable(op_ff)))
      else $error("write-back without a preceding multiply of the same step");

   a_result_after_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SLEW) |-> (op_ff == tbl_pkg::OP_LAST))
      else $error("slew step reached before the last datapath step");

endmodule

/* rtl/tilt_bubble_level_tracker.sv */
// Top level of the tilt bubble level tracker.
//
// One request carries an X/Y acceleration sample in signed Q3.12 g. Each
// request produces exactly one result with the level flag and the bubble
// row and column on the matrix. The user must write registers over the
// APB-style port only while the block is idle; the block itself does not
// enforce this. Reads return the stored values. A request passes through
// ten multiply and write-back steps that all share one 25 by 25 bit
// multiplier, then a slew step and the result load; the next request is
// accepted only after that result load.
// A finished result sits in an output register, so the next request is
// accepted while the receiver stalls; the sequence then waits before the
// result load until that register has been taken.
// Reset returns the configuration registers to their defaults, clears the
// tilt filters and the level latch, and centers the bubble.
module tilt_bubble_level_tracker #(
   parameter int MATRIX_COLS = tbl_pkg::MATRIX_COLS_DEF,
   parameter int MATRIX_ROWS = tbl_pkg::MATRIX_ROWS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // x_accel [15:0], y_accel [31:16]
   input  logic [tbl_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // is_level [0], dot_row [3:1], dot_col [6:4], zero [7]
   output logic [tbl_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [tbl_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [tbl_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [tbl_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   tbl_pkg::cfg_type cfg;
   tbl_pkg::cmd_type cmd;

   tbl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tbl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   tbl_datapath #(
      .MATRIX_COLS (MATRIX_COLS),
      .MATRIX_ROWS (MATRIX_ROWS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .cfg      (cfg),
      .req_data (req_tdata),
      .rsp_data (rsp_tdata)
   );

endmodule
